>>> rtl/cnw_pkg.sv
// Shared types, constants and helpers for the character LCD nibble writer.
`default_nettype none
package cnw_pkg;

	// Display geometry defaults.
	localparam int COLUMNS_DEF = 20;
	localparam int ROWS_DEF    = 4;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;

	// Input operations.
	typedef enum logic [1:0] {
		OP_COMMAND = 2'd0,
		OP_DATA    = 2'd1,
		OP_CURSOR  = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_STROBE    = 2'd0;
	localparam logic [1:0] REG_CMD_WAIT  = 2'd1;
	localparam logic [1:0] REG_DATA_WAIT = 2'd2;

	// Controller commands.
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_HOME      = 8'h02;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

	// Register reset values.
	localparam logic [7:0]  STROBE_RST    = 8'd1;
	localparam logic [15:0] CMD_WAIT_RST  = 16'd2000;
	localparam logic [15:0] DATA_WAIT_RST = 16'd37;

	// Work item handed from the front to the back.
	typedef struct packed {
		logic       rejected;
		logic       rs;
		logic       clear;
		logic [7:0] cmd;
		logic [4:0] col;
		logic [1:0] row;
	} entry_t;

	// Live configuration seen by the back part.
	typedef struct packed {
		logic [7:0]  strobe_us;
		logic [15:0] command_wait_us;
		logic [15:0] data_wait_us;
	} cfg_t;

	// DDRAM start address of each display row.
	function automatic logic [7:0] row_offset(input logic [1:0] row);
		logic [7:0] off;
		case (row)
			2'd0:    off = 8'h00;
			2'd1:    off = 8'h40;
			2'd2:    off = 8'h14;
			default: off = 8'h54;
		endcase
		return off;
	endfunction

endpackage
`default_nettype wire

>>> rtl/cnw_front.sv
// Front part: classifies requests, checks cursor moves, keeps the cursor.
`default_nettype none
module cnw_front #(
	parameter int COLUMNS = cnw_pkg::COLUMNS_DEF,
	parameter int ROWS    = cnw_pkg::ROWS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      in_op,
	input  wire logic [7:0]      in_value,
	input  wire logic [4:0]      in_col,
	input  wire logic [2:0]      in_row,
	input  wire logic            q_full,
	output logic                 q_push,
	output cnw_pkg::entry_t      q_entry
);

	logic [4:0] cur_col_q;
	logic [1:0] cur_row_q;
	logic       in_range;
	logic [4:0] next_col;
	logic [1:0] next_row;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	assign in_range = ({1'b0, in_col} < 6'(COLUMNS)) && (in_row < 3'(ROWS));

	always_comb begin
		next_col         = cur_col_q;
		next_row         = cur_row_q;
		q_entry.rejected = 1'b0;
		q_entry.rs       = 1'b0;
		q_entry.clear    = 1'b0;
		q_entry.cmd      = in_value;
		unique case (cnw_pkg::op_t'(in_op))
			cnw_pkg::OP_COMMAND: begin
			end
			cnw_pkg::OP_DATA: begin
				q_entry.rs = 1'b1;
			end
			cnw_pkg::OP_CURSOR: begin
				if (in_range) begin
					next_col    = in_col;
					next_row    = in_row[1:0];
					q_entry.cmd = cnw_pkg::CMD_SET_DDRAM
						+ cnw_pkg::row_offset(in_row[1:0]) + {3'b000, in_col};
				end else begin
					q_entry.rejected = 1'b1;
				end
			end
			cnw_pkg::OP_CLEAR: begin
				next_col      = 5'd0;
				next_row      = 2'd0;
				q_entry.clear = 1'b1;
				q_entry.cmd   = cnw_pkg::CMD_CLEAR;
			end
			default: begin
			end
		endcase
		q_entry.col = next_col;
		q_entry.row = next_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 5'd0;
			cur_row_q <= 2'd0;
		end else if (q_push) begin
			cur_col_q <= next_col;
			cur_row_q <= next_row;
		end
	end

endmodule
`default_nettype wire

>>> rtl/cnw_queue.sv
// Short queue of classified requests between front and back.
`default_nettype none
module cnw_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cnw_pkg::entry_t push_entry,
	input  wire logic            pop,
	output logic                 full,
	output logic                 empty,
	output cnw_pkg::entry_t      head
);

	localparam int PW = (cnw_pkg::QUEUE_DEPTH > 1) ? $clog2(cnw_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(cnw_pkg::QUEUE_DEPTH + 1);

	cnw_pkg::entry_t slots_q [cnw_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(cnw_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(cnw_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/cnw_back.sv
// Back part: turns queued requests into nibble transfer results.
`default_nettype none
module cnw_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cnw_pkg::cfg_t   cfg,
	input  wire logic            q_empty,
	input  wire cnw_pkg::entry_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic                 out_kind,
	output logic                 out_rs,
	output logic [3:0]           out_nibble,
	output logic [7:0]           out_pulse,
	output logic [15:0]          out_wait,
	output logic [4:0]           out_col,
	output logic [1:0]           out_row,
	output logic                 out_last
);

	logic [1:0]  step_q;
	logic        out_valid_q;
	logic        advance;
	logic        fire;
	logic        final_step;
	logic [7:0]  cur_byte;
	logic [3:0]  nib;
	logic [15:0] wait_val;

	assign advance = !out_valid_q || out_ready;
	assign fire    = advance && !q_empty;
	assign q_pop   = fire && final_step;
	assign out_valid = out_valid_q;

	always_comb begin
		// second byte of a clear is the return-home command
		cur_byte   = (q_head.clear && step_q[1]) ? cnw_pkg::CMD_HOME : q_head.cmd;
		nib        = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
		wait_val   = step_q[0] ? (q_head.rs ? cfg.data_wait_us : cfg.command_wait_us)
		                       : 16'd0;
		final_step = q_head.rejected || (step_q[0] && (!q_head.clear || step_q[1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 2'd0;
		end else begin
			if (advance) begin
				out_valid_q <= !q_empty;
			end
			if (fire) begin
				step_q <= final_step ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_kind <= q_head.rejected;
			out_col  <= q_head.col;
			out_row  <= q_head.row;
			out_last <= final_step;
			if (q_head.rejected) begin
				out_rs     <= 1'b0;
				out_nibble <= 4'd0;
				out_pulse  <= 8'd0;
				out_wait   <= 16'd0;
			end else begin
				out_rs     <= q_head.rs;
				out_nibble <= nib;
				out_pulse  <= cfg.strobe_us;
				out_wait   <= wait_val;
			end
		end
	end

	// mid-request step implies the request is still queued
	a_step_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != 2'd0) |-> !q_empty)
		else $error("step counter active with empty queue");

	// a rejection is always a single, last result
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind) |-> out_last)
		else $error("rejected result not marked last");

	// high nibble never carries a wait and is never last
	a_high_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !q_head.rejected && !step_q[0]) |=> (out_wait == 16'd0 && !out_last))
		else $error("high nibble with wait or last");

	// a rejection carries nothing on the bus fields
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind) |-> (out_nibble == 4'd0 && out_pulse == 8'd0))
		else $error("rejected result with bus payload");

endmodule
`default_nettype wire

>>> rtl/char_lcd_nibble_writer_top.sv
// Top level of the character LCD nibble writer: config registers and wiring.
`default_nettype none
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: op; s_tdata: value, col, row
// m        out  m_tvalid/m_tready  m_tuser: kind, reg_select; m_tdata: transfer; m_tlast
// cfg      in   cfg_we             cfg_index, cfg_wdata
//
// A data, command or valid cursor request gives two results, a clear four
// and a rejected cursor request one; the back part has a one-result-per-cycle
// output register that holds its result while m_tready is low.
// The front accepts a request each cycle while the two-entry queue has room.
// Reset clears the cursor, the queue and the output valid flag; config
// registers return to strobe 1, command wait 2000, data wait 37.
// A stalled m_tready holds the result; the front keeps filling the queue until it is full.
module char_lcd_nibble_writer_top #(
	parameter int COLUMNS = cnw_pkg::COLUMNS_DEF,
	parameter int ROWS    = cnw_pkg::ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // value[7:0], col[12:8], row[15:13]
	input  wire logic [1:0]  s_tuser,   // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // nibble[3:0], pulse_us[11:4], wait_us[27:12],
	                                    // cursor_col[32:28], cursor_row[34:33], zero fill
	output logic [1:0]       m_tuser,   // kind[0], reg_select[1]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	cnw_pkg::cfg_t   cfg_q;
	cnw_pkg::entry_t push_entry;
	cnw_pkg::entry_t head;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;
	logic            o_kind;
	logic            o_rs;
	logic [3:0]      o_nibble;
	logic [7:0]      o_pulse;
	logic [15:0]     o_wait;
	logic [4:0]      o_col;
	logic [1:0]      o_row;

	// Config registers; index 3 is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strobe_us       <= cnw_pkg::STROBE_RST;
			cfg_q.command_wait_us <= cnw_pkg::CMD_WAIT_RST;
			cfg_q.data_wait_us    <= cnw_pkg::DATA_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cnw_pkg::REG_STROBE:    cfg_q.strobe_us       <= cfg_wdata[7:0];
				cnw_pkg::REG_CMD_WAIT:  cfg_q.command_wait_us <= cfg_wdata;
				cnw_pkg::REG_DATA_WAIT: cfg_q.data_wait_us    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	cnw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_value (s_tdata[7:0]),
		.in_col   (s_tdata[12:8]),
		.in_row   (s_tdata[15:13]),
		.q_full   (full),
		.q_push   (push),
		.q_entry  (push_entry)
	);

	cnw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.empty      (empty),
		.head       (head)
	);

	cnw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (empty),
		.q_head     (head),
		.q_pop      (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (o_kind),
		.out_rs     (o_rs),
		.out_nibble (o_nibble),
		.out_pulse  (o_pulse),
		.out_wait   (o_wait),
		.out_col    (o_col),
		.out_row    (o_row),
		.out_last   (m_tlast)
	);

	assign m_tdata = {5'd0, o_row, o_col, o_wait, o_pulse, o_nibble};
	assign m_tuser = {o_rs, o_kind};

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the character LCD nibble writer top level.
`timescale 1ns / 1ps
module testbench;
	import cnw_pkg::*;

	// Watchdog: cycles with no request, result or register write before giving up.
	// The longest legal quiet stretch is a sender gap plus a receiver stall
	// plus the idle pause between phases.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 50;

	// Index above the register map; a write there must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// One nibble transfer (or rejected cursor request) as seen on the m side.
	typedef struct {
		logic        kind;
		logic        rs;
		logic [3:0]  nibble;
		logic [7:0]  pulse_us;
		logic [15:0] wait_us;
		logic [4:0]  cursor_col;
		logic [1:0]  cursor_row;
		logic        last;
	} lcd_xfer_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // value[7:0], col[12:8], row[15:13]
	logic [1:0]  s_tuser;    // op[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // nibble[3:0], pulse_us[11:4], wait_us[27:12],
	                         // cursor_col[32:28], cursor_row[34:33], zero fill
	logic [1:0]  m_tuser;    // kind[0], reg_select[1]
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	// Shadow copy of the block's registers and kept cursor.
	logic [7:0]  strobe_sh;
	logic [15:0] cmd_wait_sh;
	logic [15:0] data_wait_sh;
	logic [4:0]  cursor_col_sh;
	logic [1:0]  cursor_row_sh;

	// Transfers predicted for accepted requests, oldest first.
	lcd_xfer_t xfer_expected[$];

	// Idling switches for the two sides; off gives back-to-back traffic.
	bit tx_idle;
	bit rx_idle;

	int error_count;
	int request_count;
	int xfer_count;
	int reject_count;
	int clear_count;
	int cfg_count;
	int quiet_cycles;

	always #6 clk = ~clk;

	char_lcd_nibble_writer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	function automatic logic [7:0] ddram_base(input logic [1:0] row);
		case (row)
			2'd0:    return 8'h00;
			2'd1:    return 8'h40;
			2'd2:    return 8'h14;
			default: return 8'h54;
		endcase
	endfunction

	function automatic void queue_xfer(input logic kind, input logic rs,
			input logic [3:0] nib, input logic [7:0] pulse, input logic [15:0] wt,
			input logic last);
		lcd_xfer_t x;
		x.kind       = kind;
		x.rs         = rs;
		x.nibble     = nib;
		x.pulse_us   = pulse;
		x.wait_us    = wt;
		x.cursor_col = cursor_col_sh;
		x.cursor_row = cursor_row_sh;
		x.last       = last;
		xfer_expected.push_back(x);
	endfunction

	// High nibble carries no wait; the low nibble carries the settle time.
	function automatic void queue_byte(input logic [7:0] b, input logic rs,
			input logic [15:0] wt, input logic last);
		queue_xfer(1'b0, rs, b[7:4], strobe_sh, 16'd0, 1'b0);
		queue_xfer(1'b0, rs, b[3:0], strobe_sh, wt, last);
	endfunction

	// Works out every transfer one request causes and updates the cursor.
	function automatic void model_request(input op_t op, input logic [7:0] value,
			input logic [4:0] col, input logic [2:0] row);
		logic [7:0] addr_cmd;
		case (op)
			OP_COMMAND: queue_byte(value, 1'b0, cmd_wait_sh, 1'b1);
			OP_DATA:    queue_byte(value, 1'b1, data_wait_sh, 1'b1);
			OP_CURSOR: begin
				if (col >= COLUMNS_DEF || row >= ROWS_DEF) begin
					// rejected: one marker result, cursor untouched
					queue_xfer(1'b1, 1'b0, 4'd0, 8'd0, 16'd0, 1'b1);
					reject_count++;
				end else begin
					cursor_col_sh = col;
					cursor_row_sh = row[1:0];
					addr_cmd = CMD_SET_DDRAM + ddram_base(row[1:0]) + {3'd0, col};
					queue_byte(addr_cmd, 1'b0, cmd_wait_sh, 1'b1);
				end
			end
			default: begin
				cursor_col_sh = '0;
				cursor_row_sh = '0;
				queue_byte(CMD_CLEAR, 1'b0, cmd_wait_sh, 1'b0);
				queue_byte(CMD_HOME, 1'b0, cmd_wait_sh, 1'b1);
				clear_count++;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s got %0h expected %0h",
				xfer_count, name, got, want));
	endtask

	// Requests are predicted before results are checked, so a short path
	// through the block never races the expectation store.
	always @(posedge clk) begin : monitor
		lcd_xfer_t got;
		lcd_xfer_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				model_request(op_t'(s_tuser), s_tdata[7:0], s_tdata[12:8], s_tdata[15:13]);
				request_count++;
			end
			if (m_tvalid && m_tready) begin
				got.kind       = m_tuser[0];
				got.rs         = m_tuser[1];
				got.nibble     = m_tdata[3:0];
				got.pulse_us   = m_tdata[11:4];
				got.wait_us    = m_tdata[27:12];
				got.cursor_col = m_tdata[32:28];
				got.cursor_row = m_tdata[34:33];
				got.last       = m_tlast;
				if (xfer_expected.size() == 0) begin
					report_error($sformatf("result with nothing pending, tdata %0h", m_tdata));
				end else begin
					want = xfer_expected.pop_front();
					check_field("kind", got.kind, want.kind);
					check_field("reg_select", got.rs, want.rs);
					check_field("nibble", got.nibble, want.nibble);
					check_field("pulse_us", got.pulse_us, want.pulse_us);
					check_field("wait_us", got.wait_us, want.wait_us);
					check_field("cursor_col", got.cursor_col, want.cursor_col);
					check_field("cursor_row", got.cursor_row, want.cursor_row);
					check_field("last", got.last, want.last);
				end
				xfer_count++;
			end
		end
	end

	// Watchdog: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no progress, %0d results pending",
				$realtime, xfer_expected.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Receiver: per result, when idling is on, a random stall with ready low.
	initial begin : sink
		int stall;
		m_tready = 1'b0;
		forever begin
			stall = rx_idle ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready && arst_n));
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Sends one request, with a random gap if idling is on; returns at the accepting
	// edge with valid still high so the next request can follow back to back.
	task automatic send_request(input op_t op, input logic [7:0] value,
			input logic [4:0] col, input logic [2:0] row);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {row, col, value};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drops valid and waits until every predicted result is back, then lets
	// the output stage settle before registers may change.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (xfer_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_STROBE:    strobe_sh    = data[7:0];
			REG_CMD_WAIT:  cmd_wait_sh  = data;
			REG_DATA_WAIT: data_wait_sh = data;
			default: ;
		endcase
		cfg_count++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random cursor target: mostly on screen, otherwise anywhere the fields reach.
	task automatic send_random_cursor();
		if ($urandom_range(0, 9) < 7)
			send_request(OP_CURSOR, 8'($urandom), 5'($urandom_range(0, 19)),
				3'($urandom_range(0, 3)));
		else
			send_request(OP_CURSOR, 8'($urandom), 5'($urandom), 3'($urandom));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Every op, field extremes, cursor corners and rejected moves at reset config.
	task automatic test_directed_ops();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_request(OP_COMMAND, 8'h00, 5'd0, 3'd0);
		send_request(OP_COMMAND, 8'hFF, 5'd31, 3'd7);   // col/row ignored
		send_request(OP_DATA, 8'h00, 5'd0, 3'd0);
		send_request(OP_DATA, 8'hFF, 5'd31, 3'd7);
		send_request(OP_DATA, 8'hA5, 5'd10, 3'd5);
		send_request(OP_CURSOR, 8'hFF, 5'd0, 3'd0);     // value ignored
		send_request(OP_CURSOR, 8'h00, 5'd19, 3'd3);    // far corner
		send_request(OP_CURSOR, 8'h00, 5'd20, 3'd0);    // column just past edge
		send_request(OP_CURSOR, 8'h00, 5'd31, 3'd3);
		send_request(OP_CURSOR, 8'h00, 5'd0, 3'd4);     // row just past edge
		send_request(OP_CURSOR, 8'h00, 5'd31, 3'd7);
		send_request(OP_CURSOR, 8'h5A, 5'd7, 3'd1);
		send_request(OP_CURSOR, 8'h00, 5'd19, 3'd2);
		send_request(OP_DATA, 8'h41, 5'd0, 3'd0);       // cursor kept across data
		send_request(OP_CLEAR, 8'hFF, 5'd31, 3'd7);     // value, col, row ignored
		send_request(OP_CURSOR, 8'h00, 5'd5, 3'd6);     // rejected right after clear
		send_request(OP_CURSOR, 8'h00, 5'd0, 3'd3);
		send_request(OP_CLEAR, 8'h00, 5'd0, 3'd0);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_request(OP_COMMAND, 8'h0F, 5'd0, 3'd0);
		send_request(OP_CLEAR, 8'h3C, 5'd12, 3'd2);
		send_request(OP_CURSOR, 8'h00, 5'd4, 3'd2);
		wait_idle();
	endtask

	// Registers at their extremes, a strobe of zero, a masked wide value and
	// a write to the unused index.
	task automatic test_register_extremes();
		write_reg(REG_STROBE, 16'd0);
		write_reg(REG_CMD_WAIT, 16'd0);
		write_reg(REG_DATA_WAIT, 16'd0);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_request(OP_COMMAND, 8'h38, 5'd0, 3'd0);
		send_request(OP_DATA, 8'h7E, 5'd0, 3'd0);
		send_request(OP_CLEAR, 8'h00, 5'd0, 3'd0);
		send_request(OP_CURSOR, 8'h00, 5'd21, 3'd1);
		wait_idle();
		write_reg(REG_STROBE, 16'hAB12);               // upper byte must drop
		write_reg(REG_CMD_WAIT, 16'hFFFF);
		write_reg(REG_DATA_WAIT, 16'hFFFF);
		send_request(OP_CURSOR, 8'h00, 5'd13, 3'd1);
		send_request(OP_DATA, 8'hC3, 5'd0, 3'd0);
		wait_idle();
		write_reg(REG_STROBE, 16'h00FF);
		send_request(OP_COMMAND, 8'h0C, 5'd0, 3'd0);
		send_request(OP_CLEAR, 8'h00, 5'd0, 3'd0);
		wait_idle();
	endtask

	// Random traffic in phases; each phase sets new registers and the idling
	// pattern is redrawn every 25 requests.
	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [1:0] opc;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 3))
				0:       write_reg(REG_STROBE, 16'd1);
				1:       write_reg(REG_STROBE, 16'd255);
				2:       write_reg(REG_STROBE, 16'($urandom));
				default: write_reg(REG_STROBE, 16'($urandom_range(1, 255)));
			endcase
			write_reg(REG_CMD_WAIT, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
			write_reg(REG_DATA_WAIT, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_UNUSED, 16'($urandom));
			for (int i = 0; i < per_phase; i++) begin
				if (i % 25 == 0) begin
					tx_idle = ($urandom_range(0, 3) != 0);
					rx_idle = ($urandom_range(0, 3) != 0);
				end
				opc = 2'($urandom_range(0, 3));
				if (op_t'(opc) == OP_CURSOR)
					send_random_cursor();
				else
					send_request(op_t'(opc), 8'($urandom), 5'($urandom), 3'($urandom));
			end
			wait_idle();
		end
	endtask

	// ---------------------------------------------------------------
	// Run
	// ---------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = OP_COMMAND;
		cfg_we        = 1'b0;
		cfg_index     = REG_STROBE;
		cfg_wdata     = '0;
		tx_idle       = 1'b0;
		rx_idle       = 1'b0;
		strobe_sh     = STROBE_RST;
		cmd_wait_sh   = CMD_WAIT_RST;
		data_wait_sh  = DATA_WAIT_RST;
		cursor_col_sh = '0;
		cursor_row_sh = '0;
		error_count   = 0;
		request_count = 0;
		xfer_count    = 0;
		reject_count  = 0;
		clear_count   = 0;
		cfg_count     = 0;
		quiet_cycles  = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_register_extremes();
		test_random_traffic(5, 76);

		// tail: catch any stray result after the last expected one
		repeat (16) @(posedge clk);

		$display("covered %0d requests (%0d clears, %0d rejected moves), %0d results",
			request_count, clear_count, reject_count, xfer_count);
		$display("%0d register writes incl. zero strobe, full waits, unused index",
			cfg_count);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
